@@ rtl/vlq_pkg.sv @@
package vlq_pkg;

    localparam int LEN_W = 28;
    localparam int GROUP_W = 7;

    typedef enum logic [1:0] {
        PH_IDLE = 2'b01,
        PH_DATA = 2'b10
    } phase_t;

    typedef enum logic [1:0] {
        KIND_LENGTH = 2'd0,
        KIND_BYTE   = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE          = 2'd0,
        ERR_END_IN_LENGTH = 2'd1,
        ERR_TOO_LONG      = 2'd2,
        ERR_END_IN_DATA   = 2'd3
    } err_t;

    typedef struct packed {
        phase_t             phase;
        logic [LEN_W-1:0]   accum;
        logic [LEN_W-1:0]   remaining;
    } frame_state_t;

    typedef struct packed {
        logic               valid;
        kind_t              kind;
        logic [LEN_W-1:0]   value;
        err_t               error_code;
        logic               last;
    } result_t;

endpackage

@@ rtl/vlq_length_prefixed_deframer.sv @@
// Channel | Direction | tdata                      | tuser                              | tlast
// s_      | in        | [7:0] data_byte            | [0] end_of_input                   | -
// m_      | out       | [27:0] value, [31:28] zero | [1:0] kind, [3:2] error_code       | last
//
// One input beat is taken in every cycle while s_tready is high; its result appears
// in the output register on the next cycle.
// Length bytes with the continuation bit set produce an output beat only on an error.
// s_tready drops only while a result waits in the output register and m_tready is low.
// aresetn is synchronous and active low; it returns the parser to idle and empties
// the output register.
module vlq_length_prefixed_deframer #(
    parameter int MAX_LENGTH_BYTES = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [27:0] value, [31:28] zero
    output logic [3:0]  m_tuser,   // [1:0] kind, [3:2] error_code
    output logic        m_tlast
);
    import vlq_pkg::*;

    localparam int CNT_W = (MAX_LENGTH_BYTES > 1) ? $clog2(MAX_LENGTH_BYTES) : 1;

    frame_state_t     state_reg, state_next;
    logic [CNT_W-1:0] seen_reg, seen_next;
    result_t          result;
    logic             out_valid_reg;
    kind_t            out_kind_reg;
    logic [LEN_W-1:0] out_value_reg;
    err_t             out_err_reg;
    logic             out_last_reg;
    logic             s_accept;

    assign s_tready = !out_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    vlq_step #(
        .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES),
        .CNT_W(CNT_W)
    ) u_step (
        .state_cur   (state_reg),
        .seen_cur    (seen_reg),
        .data_byte   (s_tdata),
        .end_of_input(s_tuser[0]),
        .state_nxt   (state_next),
        .seen_nxt    (seen_next),
        .result      (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '{phase: PH_IDLE, accum: '0, remaining: '0};
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                state_reg <= state_next;
                seen_reg  <= seen_next;
            end
            if (s_accept && result.valid) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && result.valid) begin
            out_kind_reg  <= result.kind;
            out_value_reg <= result.value;
            out_err_reg   <= result.error_code;
            out_last_reg  <= result.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(32-LEN_W){1'b0}}, out_value_reg};
    assign m_tuser  = {out_err_reg, out_kind_reg};
    assign m_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    // While in payload there is always at least one byte still owed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.phase == PH_DATA) |-> (state_reg.remaining != '0))
        else $error("payload phase with zero bytes remaining");

    // An end-of-input beat always leaves the parser idle with a clean counter.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser[0]) |=> (state_reg.phase == PH_IDLE && seen_reg == '0))
        else $error("end of input did not return parser to idle");

    // Error beats always close the record and carry a nonzero code.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_kind_reg == KIND_ERROR)
            |-> (out_last_reg && out_err_reg != ERR_NONE))
        else $error("error beat without last or code");

    // Non-error beats carry no error code.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_kind_reg != KIND_ERROR) |-> (out_err_reg == ERR_NONE))
        else $error("error code on a non-error beat");
`endif

endmodule

@@ rtl/vlq_step.sv @@
module vlq_step #(
    parameter int MAX_LENGTH_BYTES = 4,
    parameter int CNT_W = 2
) (
    input  vlq_pkg::frame_state_t state_cur,
    input  logic [CNT_W-1:0]      seen_cur,
    input  logic [7:0]            data_byte,
    input  logic                  end_of_input,
    output vlq_pkg::frame_state_t state_nxt,
    output logic [CNT_W-1:0]      seen_nxt,
    output vlq_pkg::result_t      result
);
    import vlq_pkg::*;

    localparam frame_state_t IdleState = '{phase: PH_IDLE, accum: '0, remaining: '0};

    logic [LEN_W-1:0] accum_shifted;
    logic [LEN_W-1:0] remaining_dec;
    logic [CNT_W:0]   seen_inc;

    assign accum_shifted = {state_cur.accum[LEN_W-GROUP_W-1:0], data_byte[GROUP_W-1:0]};
    assign remaining_dec = state_cur.remaining - LEN_W'(1);
    assign seen_inc      = {1'b0, seen_cur} + (CNT_W+1)'(1);

    always_comb begin
        state_nxt = state_cur;
        seen_nxt  = seen_cur;
        result    = '{valid: 1'b0, kind: KIND_LENGTH, value: '0,
                      error_code: ERR_NONE, last: 1'b0};
        unique case (state_cur.phase)
            PH_DATA: begin
                result.valid = 1'b1;
                if (end_of_input) begin
                    state_nxt         = IdleState;
                    seen_nxt          = '0;
                    result.kind       = KIND_ERROR;
                    result.error_code = ERR_END_IN_DATA;
                    result.last       = 1'b1;
                end else begin
                    result.kind  = KIND_BYTE;
                    result.value = {{(LEN_W-8){1'b0}}, data_byte};
                    if (remaining_dec == '0) begin
                        state_nxt   = IdleState;
                        seen_nxt    = '0;
                        result.last = 1'b1;
                    end else begin
                        state_nxt.remaining = remaining_dec;
                    end
                end
            end
            default: begin
                // Idle, and any stray phase code, gathers length groups.
                if (end_of_input) begin
                    state_nxt         = IdleState;
                    seen_nxt          = '0;
                    result.valid      = 1'b1;
                    result.kind       = KIND_ERROR;
                    result.error_code = ERR_END_IN_LENGTH;
                    result.last       = 1'b1;
                end else if (data_byte[7]) begin
                    if (seen_inc >= (CNT_W+1)'(MAX_LENGTH_BYTES)) begin
                        state_nxt         = IdleState;
                        seen_nxt          = '0;
                        result.valid      = 1'b1;
                        result.kind       = KIND_ERROR;
                        result.error_code = ERR_TOO_LONG;
                        result.last       = 1'b1;
                    end else begin
                        state_nxt.phase = PH_IDLE;
                        state_nxt.accum = accum_shifted;
                        seen_nxt        = seen_inc[CNT_W-1:0];
                    end
                end else begin
                    result.valid = 1'b1;
                    result.kind  = KIND_LENGTH;
                    result.value = accum_shifted;
                    seen_nxt     = '0;
                    if (accum_shifted == '0) begin
                        state_nxt   = IdleState;
                        result.last = 1'b1;
                    end else begin
                        state_nxt.phase     = PH_DATA;
                        state_nxt.accum     = '0;
                        state_nxt.remaining = accum_shifted;
                    end
                end
            end
        endcase
    end

endmodule
